[hw/rtl/cdtd_pkg.sv]
package cdtd_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned OPND_W = 32;
  localparam int unsigned PEND_W = 3;

  // token byte codes
  localparam logic [7:0] OP_LAST    = 8'd21;
  localparam logic [7:0] OP_ESCAPE  = 8'd12;
  localparam logic [7:0] LEAD_INT16 = 8'd28;
  localparam logic [7:0] LEAD_INT32 = 8'd29;
  localparam logic [7:0] LEAD_REAL  = 8'd30;
  localparam logic [7:0] SHORT_LO   = 8'd32;
  localparam logic [7:0] SHORT_HI   = 8'd246;
  localparam logic [7:0] POS2_BASE  = 8'd247;
  localparam logic [7:0] NEG2_BASE  = 8'd251;
  localparam logic [7:0] NEG2_HI    = 8'd254;
  localparam logic [3:0] REAL_END   = 4'd15;

  localparam logic [OPND_W-1:0] SHORT_BIAS = 32'd139;
  localparam logic [OPND_W-1:0] TWO_BIAS   = 32'd108;

  localparam logic [PEND_W-1:0] PEND_INT16 = 3'd2;
  localparam logic [PEND_W-1:0] PEND_INT32 = 3'd4;
  localparam logic [PEND_W-1:0] PEND_TWO   = 3'd1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ESC  = 4'b0010,
    PH_INT  = 4'b0100,
    PH_REAL = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [DATA_W-1:0] operator_code;
    logic              escaped;
    logic [OPND_W-1:0] last_operand;
    logic [OPND_W-1:0] prior_operand;
    logic              truncated;
  } res_t;

endpackage

[hw/rtl/cdtd_parse.sv]
module cdtd_parse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire_i,
  input  logic [cdtd_pkg::DATA_W-1:0] byte_i,
  input  logic                       first_i,
  input  logic                       last_i,
  output logic                       res_vld_o,
  output cdtd_pkg::res_t             res_o,
  output cdtd_pkg::phase_t           phase_o
);
  import cdtd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [PEND_W-1:0]   pend_r, pend_nxt;
  logic [DATA_W-1:0]   lead_r, lead_nxt;
  logic [OPND_W-1:0]   acc_r, acc_nxt;
  logic [OPND_W-1:0]   cur_r, cur_nxt;
  logic [OPND_W-1:0]   prev_r, prev_nxt;

  phase_t              ph0;
  logic [PEND_W-1:0]   pend0;
  logic [OPND_W-1:0]   cur0, prev0;
  logic [OPND_W-1:0]   acc_sh;
  logic [DATA_W-1:0]   two_off;
  logic [OPND_W-1:0]   two_mag;
  logic [OPND_W-1:0]   int_val;
  logic                emit;

  // a new DICT drops any open token and the operand history
  assign ph0   = first_i ? PH_IDLE : phase_r;
  assign pend0 = first_i ? '0 : pend_r;
  assign cur0  = first_i ? '0 : cur_r;
  assign prev0 = first_i ? '0 : prev_r;

  assign acc_sh  = {acc_r[OPND_W-DATA_W-1:0], byte_i};
  assign two_off = (lead_r >= NEG2_BASE) ? lead_r - NEG2_BASE : lead_r - POS2_BASE;
  assign two_mag = {{(OPND_W-10){1'b0}}, two_off[1:0], byte_i} + TWO_BIAS;

  always_comb begin
    if (lead_r >= POS2_BASE && lead_r < NEG2_BASE) begin
      int_val = two_mag;
    end else if (lead_r >= NEG2_BASE && lead_r <= NEG2_HI) begin
      int_val = '0 - two_mag;
    end else if (lead_r == LEAD_INT16) begin
      int_val = {{(OPND_W-16){acc_sh[15]}}, acc_sh[15:0]};
    end else begin
      int_val = acc_sh;
    end
  end

  always_comb begin
    phase_nxt = ph0;
    pend_nxt  = pend0;
    lead_nxt  = lead_r;
    acc_nxt   = acc_r;
    cur_nxt   = cur0;
    prev_nxt  = prev0;
    emit      = 1'b0;
    res_o     = '0;
    case (ph0)
      PH_IDLE: begin
        if (byte_i <= OP_LAST) begin
          if (byte_i == OP_ESCAPE) begin
            phase_nxt = PH_ESC;
          end else begin
            emit                = 1'b1;
            res_o.operator_code = byte_i;
            res_o.last_operand  = cur0;
            res_o.prior_operand = prev0;
          end
        end else if (byte_i == LEAD_REAL) begin
          phase_nxt = PH_REAL;
        end else if (byte_i inside {[SHORT_LO:SHORT_HI]}) begin
          prev_nxt = cur0;
          cur_nxt  = {{(OPND_W-DATA_W){1'b0}}, byte_i} - SHORT_BIAS;
        end else if (byte_i inside {[POS2_BASE:NEG2_HI], LEAD_INT16, LEAD_INT32}) begin
          lead_nxt  = byte_i;
          acc_nxt   = '0;
          phase_nxt = PH_INT;
          if (byte_i == LEAD_INT16) begin
            pend_nxt = PEND_INT16;
          end else if (byte_i == LEAD_INT32) begin
            pend_nxt = PEND_INT32;
          end else begin
            pend_nxt = PEND_TWO;
          end
        end
      end
      PH_ESC: begin
        emit                = 1'b1;
        res_o.operator_code = byte_i;
        res_o.escaped       = 1'b1;
        res_o.last_operand  = cur0;
        res_o.prior_operand = prev0;
        phase_nxt           = PH_IDLE;
      end
      PH_INT: begin
        acc_nxt  = acc_sh;
        pend_nxt = pend0 - PEND_W'(1);
        if (pend0 == PEND_TWO) begin
          prev_nxt  = cur0;
          cur_nxt   = int_val;
          phase_nxt = PH_IDLE;
        end
      end
      PH_REAL: begin
        if (byte_i[7:4] == REAL_END || byte_i[3:0] == REAL_END) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    // DICT ended inside a token
    if (last_i && phase_nxt != PH_IDLE) begin
      emit            = 1'b1;
      res_o           = '0;
      res_o.truncated = 1'b1;
      phase_nxt       = PH_IDLE;
      pend_nxt        = '0;
    end
  end

  assign res_vld_o = fire_i && emit;
  assign phase_o   = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r  <= '0;
      cur_r   <= '0;
      prev_r  <= '0;
    end else if (fire_i) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      cur_r   <= cur_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_i) begin
      lead_r <= lead_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

[hw/rtl/cdtd_out_reg.sv]
module cdtd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_vld_i,
  input  cdtd_pkg::res_t res_i,
  input  logic           out_ready_i,
  output logic           load_o,
  output logic           out_vld_o,
  output cdtd_pkg::res_t out_res_o
);
  import cdtd_pkg::*;

  logic vld_r;
  res_t res_r;

  // take a new item whenever the held result is gone or leaves this cycle
  assign load_o    = !vld_r || out_ready_i;
  assign out_vld_o = vld_r;
  assign out_res_o = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load_o) begin
      vld_r <= res_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load_o && res_vld_i) begin
      res_r <= res_i;
    end
  end

endmodule

[hw/rtl/cff_dict_token_decoder.sv]
// Channel  Dir  tdata                                          tuser               tlast
// in_      in   [7:0] data_byte                                [0] first_byte      last_byte
// out_     out  [7:0] op code, [39:8] last, [71:40] prior opnd [0] escaped, [1] trunc  -
//
// One byte is accepted per cycle while in_tready is high; its result, if any,
// shows in the next cycle from the output register. The parse phase and operand
// registers settle in the cycle the byte is taken. rst_n clears the phase and
// operand history. in_tready drops only while a result is held and out_tready is low.
module cff_dict_token_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] operator_code, [39:8] last_operand,
                                  // [71:40] prior_operand
  output logic [1:0]  out_tuser   // [0] escaped, [1] truncated
);
  import cdtd_pkg::*;

  logic   fire;
  logic   res_vld;
  res_t   res;
  res_t   out_res;
  phase_t phase;

  assign fire = in_tvalid && in_tready;

  cdtd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire_i    (fire),
    .byte_i    (in_tdata),
    .first_i   (in_tuser),
    .last_i    (in_tlast),
    .res_vld_o (res_vld),
    .res_o     (res),
    .phase_o   (phase)
  );

  cdtd_out_reg u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .out_ready_i (out_tready),
    .load_o      (in_tready),
    .out_vld_o   (out_tvalid),
    .out_res_o   (out_res)
  );

  assign out_tdata = {out_res.prior_operand, out_res.last_operand, out_res.operator_code};
  assign out_tuser = {out_res.truncated, out_res.escaped};

`ifndef SYNTH
  a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0 && !out_tuser[0])
    else $error("truncation result carries data");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_tlast |=> phase == PH_IDLE)
    else $error("parse left open after last byte");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_vld |=> out_tvalid)
    else $error("result lost");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import cdtd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } dict_byte_t;

  // Tracks the token parse and holds the operator results still to come out.
  class dict_token_board;
    phase_t            phase;
    logic [PEND_W-1:0] pending;
    logic [7:0]        lead;
    logic [OPND_W-1:0] acc;
    logic [OPND_W-1:0] cur_opnd;
    logic [OPND_W-1:0] prev_opnd;
    res_t              expected_tokens[$];
    int                errors;

    function new();
      clear_history();
      errors = 0;
    endfunction

    function void clear_history();
      phase     = PH_IDLE;
      pending   = '0;
      lead      = '0;
      acc       = '0;
      cur_opnd  = '0;
      prev_opnd = '0;
    endfunction

    function void push_operand(logic [OPND_W-1:0] v);
      prev_opnd = cur_opnd;
      cur_opnd  = v;
    endfunction

    function void note_byte(logic [7:0] b, logic first, logic last);
      res_t              r;
      logic [OPND_W-1:0] l32;
      logic [OPND_W-1:0] v;
      bit                got;
      got = 0;
      r   = '0;
      l32 = {24'd0, lead};
      if (first) clear_history();
      case (phase)
        PH_IDLE: begin
          if (b <= OP_LAST) begin
            if (b == OP_ESCAPE) begin
              phase = PH_ESC;
            end else begin
              r.operator_code = b;
              r.last_operand  = cur_opnd;
              r.prior_operand = prev_opnd;
              got = 1;
            end
          end else if (b == LEAD_REAL) begin
            phase = PH_REAL;
          end else if (b >= SHORT_LO && b <= SHORT_HI) begin
            push_operand({24'd0, b} - SHORT_BIAS);
          end else if ((b >= POS2_BASE && b <= NEG2_HI) || b == LEAD_INT16 ||
                       b == LEAD_INT32) begin
            lead    = b;
            acc     = '0;
            pending = (b == LEAD_INT16) ? PEND_INT16 :
                      (b == LEAD_INT32) ? PEND_INT32 : PEND_TWO;
            phase   = PH_INT;
          end
        end
        PH_ESC: begin
          r.operator_code = b;
          r.escaped       = 1'b1;
          r.last_operand  = cur_opnd;
          r.prior_operand = prev_opnd;
          got   = 1;
          phase = PH_IDLE;
        end
        PH_INT: begin
          acc = {acc[23:0], b};
          if (pending != 0) pending = pending - PEND_W'(1);
          if (pending == 0) begin
            l32 = {24'd0, lead};
            if (lead >= POS2_BASE && lead < NEG2_BASE) begin
              v = ((l32 - POS2_BASE) << 8) + acc[7:0] + TWO_BIAS;
            end else if (lead >= NEG2_BASE && lead <= NEG2_HI) begin
              v = 32'd0 - (((l32 - NEG2_BASE) << 8) + acc[7:0] + TWO_BIAS);
            end else if (lead == LEAD_INT16) begin
              v = {{16{acc[15]}}, acc[15:0]};
            end else begin
              v = acc;
            end
            push_operand(v);
            phase = PH_IDLE;
          end
        end
        default: begin
          if (b[7:4] == REAL_END || b[3:0] == REAL_END) phase = PH_IDLE;
        end
      endcase
      // a DICT that ends inside a token reports truncation and drops the token
      if (last && phase != PH_IDLE) begin
        r           = '0;
        r.truncated = 1'b1;
        got         = 1;
        phase       = PH_IDLE;
        pending     = '0;
      end
      if (got) expected_tokens.push_back(r);
    endfunction

    function void check_token(logic [71:0] tdata, logic [1:0] tuser);
      res_t want;
      res_t seen;
      seen.operator_code = tdata[7:0];
      seen.last_operand  = tdata[39:8];
      seen.prior_operand = tdata[71:40];
      seen.escaped       = tuser[0];
      seen.truncated     = tuser[1];
      if (expected_tokens.size() == 0) begin
        if (errors < 10)
          $display("%0t: result with none expected: op %0d esc %0b last %0d prior %0d trunc %0b",
                   $time, seen.operator_code, seen.escaped, $signed(seen.last_operand),
                   $signed(seen.prior_operand), seen.truncated);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      if (seen.operator_code !== want.operator_code || seen.escaped !== want.escaped ||
          seen.last_operand !== want.last_operand ||
          seen.prior_operand !== want.prior_operand || seen.truncated !== want.truncated) begin
        if (errors < 10) begin
          $display("%0t: mismatch: expected op %0d esc %0b last %0d prior %0d trunc %0b",
                   $time, want.operator_code, want.escaped, $signed(want.last_operand),
                   $signed(want.prior_operand), want.truncated);
          $display("%0t:           actual   op %0d esc %0b last %0d prior %0d trunc %0b",
                   $time, seen.operator_code, seen.escaped, $signed(seen.last_operand),
                   $signed(seen.prior_operand), seen.truncated);
        end
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] data_byte
  logic        in_tuser = 1'b0;  // [0] first_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;        // [7:0] operator_code, [39:8] last_operand,
                                 // [71:40] prior_operand
  logic [1:0]  out_tuser;        // [0] escaped, [1] truncated

  dict_token_board sb = new();
  dict_byte_t      stim[$];
  logic [7:0]      dict_bytes[$];
  int              items_sent = 0;
  bit              snd_idle = 0;
  int              snd_pct = 77;
  logic            rcv_stall = 1'b0;
  int              rcv_pct = 77;
  int              hold_req = 0;
  int              hold_seen = 0;
  int              hold_left = 0;

  cff_dict_token_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (rcv_stall && $urandom_range(99) < rcv_pct) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_token(out_tdata, out_tuser);
  end

  task automatic push_item(logic [7:0] d, logic f, logic l);
    dict_byte_t it;
    it.data  = d;
    it.first = f;
    it.last  = l;
    stim.push_back(it);
  endtask

  task automatic send_stim();
    dict_byte_t it;
    while (stim.size() != 0) begin
      it = stim.pop_front();
      while (snd_idle && $urandom_range(99) < snd_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= it.data;
      in_tuser  <= it.first;
      in_tlast  <= it.last;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      sb.note_byte(it.data, it.first, it.last);
      items_sent++;
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] real_nibbles();
    logic [3:0] hi;
    logic [3:0] lo;
    hi = 4'($urandom_range(14));
    lo = 4'($urandom_range(14));
    return {hi, lo};
  endfunction

  task automatic add_operand();
    int k;
    k = $urandom_range(5);
    case (k)
      0: dict_bytes.push_back(8'($urandom_range(SHORT_LO, SHORT_HI)));
      1: begin
        dict_bytes.push_back(8'($urandom_range(POS2_BASE, NEG2_BASE - 1)));
        dict_bytes.push_back(8'($urandom_range(255)));
      end
      2: begin
        dict_bytes.push_back(8'($urandom_range(NEG2_BASE, NEG2_HI)));
        dict_bytes.push_back(8'($urandom_range(255)));
      end
      3: begin
        dict_bytes.push_back(LEAD_INT16);
        repeat (2) dict_bytes.push_back(8'($urandom_range(255)));
      end
      4: begin
        dict_bytes.push_back(LEAD_INT32);
        repeat (4) dict_bytes.push_back(8'($urandom_range(255)));
      end
      default: begin
        dict_bytes.push_back(8'(SHORT_LO + $urandom_range(SHORT_HI - SHORT_LO)));
      end
    endcase
  endtask

  task automatic add_real();
    dict_bytes.push_back(LEAD_REAL);
    repeat ($urandom_range(3)) dict_bytes.push_back(real_nibbles());
    case ($urandom_range(2))
      0: dict_bytes.push_back({REAL_END, 4'($urandom_range(15))});
      1: dict_bytes.push_back({4'($urandom_range(14)), REAL_END});
      default: dict_bytes.push_back(8'hff);
    endcase
  endtask

  task automatic add_operator();
    logic [7:0] op;
    op = 8'($urandom_range(OP_LAST));
    dict_bytes.push_back(op);
    if (op == OP_ESCAPE) dict_bytes.push_back(8'($urandom_range(255)));
  endtask

  // leave a token open at the end of the DICT
  task automatic add_partial();
    case ($urandom_range(4))
      0: dict_bytes.push_back(OP_ESCAPE);
      1: begin
        dict_bytes.push_back(LEAD_INT16);
        repeat ($urandom_range(1)) dict_bytes.push_back(8'($urandom_range(255)));
      end
      2: begin
        dict_bytes.push_back(LEAD_INT32);
        repeat ($urandom_range(3)) dict_bytes.push_back(8'($urandom_range(255)));
      end
      3: dict_bytes.push_back(8'($urandom_range(POS2_BASE, NEG2_HI)));
      default: begin
        dict_bytes.push_back(LEAD_REAL);
        repeat ($urandom_range(2)) dict_bytes.push_back(real_nibbles());
      end
    endcase
  endtask

  task automatic build_dict();
    int  ntok;
    int  kind;
    int  ending;
    bit  mark_last;
    logic [7:0] reserved[8];
    reserved = '{8'd22, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd31, 8'd255};
    dict_bytes = {};
    mark_last  = 1;
    ntok = $urandom_range(1, 10);
    for (int i = 0; i < ntok; i++) begin
      kind = $urandom_range(99);
      if (i == ntok - 1 || kind < 25) add_operator();
      else if (kind < 80) add_operand();
      else if (kind < 92) add_real();
      else dict_bytes.push_back(reserved[3'($urandom_range(7))]);
    end
    ending = $urandom_range(99);
    if (ending < 22) add_partial();
    // without its last flag the open token is abandoned by the next DICT
    if (ending >= 15 && ending < 22) mark_last = 0;
    for (int j = 0; j < dict_bytes.size(); j++)
      push_item(dict_bytes[j], j == 0, mark_last && j == dict_bytes.size() - 1);
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 6))
      push_item(8'($urandom_range(255)), $urandom_range(7) == 0, $urandom_range(7) == 0);
  endtask

  task automatic build_directed();
    push_item(8'd0, 1, 0);               // operator with cleared history
    push_item(SHORT_LO, 0, 0);           // -107
    push_item(SHORT_HI, 0, 0);           // 107
    push_item(OP_LAST, 0, 0);
    push_item(POS2_BASE, 0, 0);          // 108
    push_item(8'd0, 0, 0);
    push_item(NEG2_HI, 0, 0);            // -1131
    push_item(8'd255, 0, 0);
    push_item(OP_ESCAPE, 0, 0);
    push_item(8'd255, 0, 0);
    push_item(LEAD_INT16, 0, 0);         // sign-extended -32768
    push_item(8'h80, 0, 0);
    push_item(8'h00, 0, 0);
    push_item(LEAD_INT32, 0, 0);         // most negative 32-bit value
    push_item(8'h80, 0, 0);
    push_item(8'h00, 0, 0);
    push_item(8'h00, 0, 0);
    push_item(8'h00, 0, 0);
    push_item(LEAD_REAL, 0, 0);          // real leaves history alone
    push_item(8'h1f, 0, 0);
    push_item(8'd255, 0, 0);             // reserved, ignored
    push_item(8'd17, 0, 0);
    push_item(LEAD_INT32, 0, 0);         // cut off by the end of the DICT
    push_item(8'h12, 0, 1);
    push_item(8'd5, 1, 1);               // one-byte DICT
  endtask

  initial begin
    int start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    send_stim();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      snd_idle  = (ph == 1 || ph == 3);
      snd_pct   = (ph == 3) ? 31 : 77;
      rcv_stall <= (ph == 2 || ph == 3);
      rcv_pct   <= (ph == 3) ? 31 : 77;
      start = items_sent;
      while (items_sent - start < 190) begin
        // long receiver hold-off midway through the unthrottled phase
        if (ph == 0 && items_sent - start >= 60 && hold_req == 0) hold_req <= 1;
        if ($urandom_range(99) < 80) build_dict();
        else build_noise();
        send_stim();
        // sender pause until everything outstanding has come out
        if (ph == 2 && items_sent - start >= 90 && items_sent - start < 110) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.expected_tokens.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
